// ----- rtl/fbsq_pkg.sv -----
// ----------------------------------------------------------------------------
// fbsq_pkg
// shared types and constants of the frame buffer slot queue
// ----------------------------------------------------------------------------
package fbsq_pkg;

    localparam int SLOT_COUNT = 32;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int XFORM_W    = 8;
    localparam int TIME_W     = 64;
    localparam int DATA_W     = XFORM_W + TIME_W;

    typedef enum logic [2:0] {
        CMD_DEQUEUE = 3'd0,
        CMD_REQUEST = 3'd1,
        CMD_QUEUE   = 3'd2,
        CMD_CANCEL  = 3'd3,
        CMD_ACQUIRE = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_INVALID = 2'd1,
        STS_BUSY    = 2'd2,
        STS_RETRY   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SL_FREE   = 2'd0,
        SL_DEQ    = 2'd1,
        SL_QUEUED = 2'd2
    } t_slot_st;

    typedef enum logic [1:0] {
        CFG_SYNC   = 2'd0,
        CFG_CLIENT = 2'd1,
        CFG_COUNT  = 2'd2,
        CFG_XFORM  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              deq_any;
        logic              hit;
        logic [SLOT_W-1:0] hit_idx;
        logic              cur_ok;
    } t_scan;

endpackage

// ----- rtl/fbsq_ram.sv -----
// ----------------------------------------------------------------------------
// fbsq_ram
// single write, single read synchronous memory with registered read data
// ----------------------------------------------------------------------------
module fbsq_ram
    import fbsq_pkg::*;
#(
    parameter int WIDTH = DATA_W
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [SLOT_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [SLOT_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [SLOT_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- rtl/fbsq_scan.sv -----
// ----------------------------------------------------------------------------
// fbsq_scan
// priority search for the lowest free slot that is not current
// ----------------------------------------------------------------------------
module fbsq_scan
    import fbsq_pkg::*;
(
    input  logic [SLOT_COUNT-1:0][1:0] i_states,
    input  logic [CNT_W-1:0]           i_cnt,
    input  logic                       i_cur_valid,
    input  logic [SLOT_W-1:0]          i_cur_idx,
    output t_scan                      o_scan
);

    always_comb begin
        o_scan = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (CNT_W'(i) < i_cnt) begin
                if (i_states[i] == SL_FREE &&
                    !(i_cur_valid && i_cur_idx == SLOT_W'(i))) begin
                    // dequeued slots above the lowest hit are not seen
                    o_scan.deq_any = 1'b0;
                    o_scan.hit     = 1'b1;
                    o_scan.hit_idx = SLOT_W'(i);
                end else if (i_states[i] == SL_DEQ) begin
                    o_scan.deq_any = 1'b1;
                end
            end
        end
        o_scan.cur_ok = i_cur_valid && ({1'b0, i_cur_idx} < i_cnt);
    end

endmodule

// ----- rtl/frame_buffer_slot_queue.sv -----
// ----------------------------------------------------------------------------
// frame_buffer_slot_queue
// slot ownership tracking and frame queue between a producer and a consumer
// ----------------------------------------------------------------------------
// the result is registered in the exec state; an acquire that takes a new
//   current slot also passes a data state (fifo memory read, then slot data
//   memory read); busy covers them, and no new item is taken until idle
// reset: synchronous, all slots free, fifo empty, no current slot
// results are strobed for one cycle, the receiver cannot stall
module frame_buffer_slot_queue
    import fbsq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [7:0]          i_cfg_data,
    input  logic [2:0]          i_cmd,
    input  logic [4:0]          i_slot,
    input  logic signed [63:0]  i_timestamp,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic [4:0]          o_out_slot,
    output logic                o_frame_available,
    output logic                o_new_current,
    output logic [7:0]          o_out_transform,
    output logic signed [63:0]  o_out_timestamp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DATA = 3'b100
    } t_state;

    t_state r_state;

    logic                  r_sync, r_client;
    logic [5:0]            r_bcount;
    logic [XFORM_W-1:0]    r_xform;

    logic [SLOT_COUNT-1:0][1:0] r_slot_st;
    logic [SLOT_COUNT-1:0]      r_req;
    logic [SLOT_W-1:0]          r_head;
    logic [CNT_W-1:0]           r_count;
    logic                       r_cur_valid;
    logic [SLOT_W-1:0]          r_cur_idx;
    logic [XFORM_W-1:0]         r_cur_xform;
    logic [TIME_W-1:0]          r_cur_time;

    logic [2:0]            r_cmd;
    logic [SLOT_W-1:0]     r_slot;
    logic [TIME_W-1:0]     r_ts;

    logic [CNT_W-1:0]      cnt;
    t_scan                 scan;
    logic                  accept;
    logic                  is_cur_s;
    logic                  queue_ok;
    logic                  push;
    logic                  acq_new;
    logic [SLOT_W-1:0]     fifo_rd;
    logic [DATA_W-1:0]     data_rd;
    logic                  fifo_we, data_we;
    logic [SLOT_W-1:0]     fifo_waddr, data_raddr;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        if (r_bcount < 6'd2) begin
            cnt = CNT_W'(2);
        end else if (7'(r_bcount) > 7'(SLOT_COUNT)) begin
            cnt = CNT_W'(SLOT_COUNT);
        end else begin
            cnt = CNT_W'(r_bcount);
        end
    end

    fbsq_scan u_scan (
        .i_states    (r_slot_st),
        .i_cnt       (cnt),
        .i_cur_valid (r_cur_valid),
        .i_cur_idx   (r_cur_idx),
        .o_scan      (scan)
    );

    assign is_cur_s = r_cur_valid && (r_cur_idx == r_slot);
    assign queue_ok = ({1'b0, r_slot} < cnt) && (r_slot_st[r_slot] == SL_DEQ) &&
                      !is_cur_s && r_req[r_slot] &&
                      !((r_sync || r_count == '0) && r_count >= CNT_W'(SLOT_COUNT));
    assign push     = r_sync || (r_count == '0);
    assign acq_new  = (r_cmd == CMD_ACQUIRE) && (r_count != '0) &&
                      !(r_cur_valid && r_cur_idx == fifo_rd);

    assign fifo_we    = (r_state == S_EXEC) && (r_cmd == CMD_QUEUE) && queue_ok;
    assign data_we    = fifo_we;
    assign fifo_waddr = push ? (r_head + r_count[SLOT_W-1:0]) : r_head;
    assign data_raddr = fifo_rd;

    fbsq_ram #(.WIDTH(SLOT_W)) u_fifo (
        .i_clk   (i_clk),
        .i_we    (fifo_we),
        .i_waddr (fifo_waddr),
        .i_wdata (r_slot),
        .i_raddr (r_head),
        .o_rdata (fifo_rd)
    );

    fbsq_ram #(.WIDTH(DATA_W)) u_data (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (r_slot),
        .i_wdata ({r_xform, r_ts}),
        .i_raddr (data_raddr),
        .o_rdata (data_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sync      <= 1'b0;
            r_client    <= 1'b0;
            r_bcount    <= 6'd3;
            r_xform     <= '0;
            r_slot_st   <= '0;
            r_req       <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_cur_valid <= 1'b0;
            r_cur_idx   <= '0;
            r_cur_xform <= '0;
            r_cur_time  <= '0;
            o_valid     <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SYNC:   r_sync   <= i_cfg_data[0];
                    CFG_CLIENT: r_client <= i_cfg_data[0];
                    CFG_COUNT:  r_bcount <= i_cfg_data[5:0];
                    CFG_XFORM:  r_xform  <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd   <= i_cmd;
                        r_slot  <= i_slot;
                        r_ts    <= i_timestamp;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state           <= S_IDLE;
                    o_valid           <= !acq_new;
                    o_status          <= STS_OK;
                    o_out_slot        <= '0;
                    o_frame_available <= 1'b0;
                    o_new_current     <= 1'b0;
                    o_out_transform   <= '0;
                    o_out_timestamp   <= '0;
                    case (r_cmd)
                        CMD_DEQUEUE: begin
                            if (!r_client && scan.deq_any) begin
                                o_status <= STS_INVALID;
                            end else if (scan.hit) begin
                                r_slot_st[scan.hit_idx] <= SL_DEQ;
                                o_out_slot <= scan.hit_idx;
                            end else if (r_sync && scan.cur_ok) begin
                                r_slot_st[r_cur_idx] <= SL_DEQ;
                                o_out_slot <= r_cur_idx;
                            end else begin
                                o_status <= r_sync ? STS_RETRY : STS_BUSY;
                            end
                        end
                        CMD_REQUEST: begin
                            if ({1'b0, r_slot} < cnt) begin
                                r_req[r_slot] <= 1'b1;
                            end else begin
                                o_status <= STS_INVALID;
                            end
                        end
                        CMD_QUEUE: begin
                            if (queue_ok) begin
                                o_frame_available <= (r_count == '0);
                                if (push) begin
                                    r_count <= r_count + 1'b1;
                                end else begin
                                    r_slot_st[fifo_rd] <= SL_FREE;
                                end
                                r_slot_st[r_slot] <= SL_QUEUED;
                            end else begin
                                o_status <= STS_INVALID;
                            end
                        end
                        CMD_CANCEL: begin
                            if ({1'b0, r_slot} < cnt && r_slot_st[r_slot] == SL_DEQ) begin
                                r_slot_st[r_slot] <= SL_FREE;
                            end else begin
                                o_status <= STS_INVALID;
                            end
                        end
                        CMD_ACQUIRE: begin
                            o_out_slot      <= r_cur_idx;
                            o_out_transform <= r_cur_xform;
                            o_out_timestamp <= r_cur_time;
                            if (r_count != '0) begin
                                r_head  <= r_head + 1'b1;
                                r_count <= r_count - 1'b1;
                                if (acq_new) begin
                                    if (r_cur_valid && r_slot_st[r_cur_idx] == SL_QUEUED) begin
                                        r_slot_st[r_cur_idx] <= SL_FREE;
                                    end
                                    r_cur_valid <= 1'b1;
                                    r_cur_idx   <= fifo_rd;
                                    r_state     <= S_DATA;
                                end
                            end
                        end
                        default: begin
                            o_status <= STS_INVALID;
                        end
                    endcase
                end
                S_DATA: begin
                    r_state           <= S_IDLE;
                    r_cur_xform       <= data_rd[DATA_W-1:TIME_W];
                    r_cur_time        <= data_rd[TIME_W-1:0];
                    o_valid           <= 1'b1;
                    o_status          <= STS_OK;
                    o_out_slot        <= r_cur_idx;
                    o_frame_available <= 1'b0;
                    o_new_current     <= 1'b1;
                    o_out_transform   <= data_rd[DATA_W-1:TIME_W];
                    o_out_timestamp   <= data_rd[TIME_W-1:0];
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- sim/tb_frame_buffer_slot_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_buffer_slot_queue
// self-checking bench for the frame buffer slot queue: a directed table, then
// random command streams over several register settings, each result checked
// against a slot ownership predictor kept inside the bench
// ----------------------------------------------------------------------------
module tb_frame_buffer_slot_queue;
    import fbsq_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int N_DIR          = 22;
    localparam int N_PHASE        = 8;
    localparam int ITEMS_PER_PH   = 230;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  slot;
        logic        favail;
        logic        newcur;
        logic [7:0]  xform;
        logic [63:0] stamp;
    } t_result;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [4:0]  slot;
        logic [63:0] stamp;
        logic        typed;
        logic [1:0]  status;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [7:0]         i_cfg_data = '0;
    logic [2:0]         i_cmd = '0;
    logic [4:0]         i_slot = '0;
    logic signed [63:0] i_timestamp = '0;
    logic               o_valid;
    logic [1:0]         o_status;
    logic [4:0]         o_out_slot;
    logic               o_frame_available;
    logic               o_new_current;
    logic [7:0]         o_out_transform;
    logic signed [63:0] o_out_timestamp;

    frame_buffer_slot_queue i_dut (.*);

    always #6 i_clk = ~i_clk;

    // predicted block state
    logic        m_sync, m_client;
    logic [5:0]  m_count;
    logic [7:0]  m_xform;
    t_slot_st    m_state [SLOT_COUNT];
    logic        m_req   [SLOT_COUNT];
    logic [7:0]  m_sxf   [SLOT_COUNT];
    logic [63:0] m_stime [SLOT_COUNT];
    logic [4:0]  m_fifo  [SLOT_COUNT];
    int          m_head, m_fcnt;
    logic        m_cur_v;
    logic [4:0]  m_cur_i;
    logic [7:0]  m_cur_xf;
    logic [63:0] m_cur_t;

    t_result     pending_results [$];
    int          fails = 0, n_items = 0, n_results = 0, idle_mode = 0;
    int          quiet = 0;
    t_row        dir_tab [0:N_DIR-1];

    logic [7:0]  ph_sync [N_PHASE] = '{0, 1, 1, 0, 1, 0, 1, 0};
    logic [7:0]  ph_cli  [N_PHASE] = '{0, 0, 1, 1, 1, 0, 1, 1};
    logic [7:0]  ph_cnt  [N_PHASE] = '{3, 32, 2, 32, 63, 0, 7, 1};
    logic [7:0]  ph_xf   [N_PHASE] = '{0, 255, 8'h5a, 8'h81, 255, 0, 8'h3c, 8'ha5};

    function automatic int slots_in_use();
        if (m_count < 2) return 2;
        if (m_count > SLOT_COUNT) return SLOT_COUNT;
        return m_count;
    endfunction

    function automatic bit is_cur(int i);
        return m_cur_v && m_cur_i == i;
    endfunction

    task automatic predict_slot_op(input logic [2:0] c, input logic [4:0] s,
                                   input logic [63:0] ts, output t_result r);
        int cnt, found, fsync, ndeq, b, old;
        r = '0;
        cnt = slots_in_use();
        found = -1; fsync = -1; ndeq = 0;
        case (c)
            CMD_DEQUEUE: begin
                for (int i = 0; i < cnt && found < 0; i++) begin
                    if (m_state[i] == SL_DEQ) ndeq++;
                    if (m_state[i] == SL_FREE || is_cur(i)) begin
                        fsync = i;
                        if (!is_cur(i)) found = i;
                    end
                end
                if (!m_client && ndeq != 0) r.status = STS_INVALID;
                else if (m_sync && fsync < 0) r.status = STS_RETRY;
                else begin
                    if (m_sync && found < 0) found = fsync;
                    if (found < 0) r.status = STS_BUSY;
                    else begin
                        m_state[found] = SL_DEQ;
                        r.slot = 5'(found);
                    end
                end
            end
            CMD_REQUEST: begin
                if (s < cnt) m_req[s] = 1'b1;
                else r.status = STS_INVALID;
            end
            CMD_QUEUE: begin
                if (s >= cnt || m_state[s] != SL_DEQ || is_cur(s) || !m_req[s])
                    r.status = STS_INVALID;
                else if ((m_sync || m_fcnt == 0) && m_fcnt >= SLOT_COUNT)
                    r.status = STS_INVALID;
                else begin
                    r.favail = (m_fcnt == 0);
                    if (m_sync || m_fcnt == 0) begin
                        m_fifo[(m_head + m_fcnt) % SLOT_COUNT] = s;
                        m_fcnt++;
                    end else begin
                        old = m_fifo[m_head];
                        m_state[old] = SL_FREE;
                        m_fifo[m_head] = s;
                    end
                    m_state[s] = SL_QUEUED;
                    m_sxf[s] = m_xform;
                    m_stime[s] = ts;
                end
            end
            CMD_CANCEL: begin
                if (s < cnt && m_state[s] == SL_DEQ) m_state[s] = SL_FREE;
                else r.status = STS_INVALID;
            end
            CMD_ACQUIRE: begin
                if (m_fcnt != 0) begin
                    b = m_fifo[m_head];
                    m_head = (m_head + 1) % SLOT_COUNT;
                    m_fcnt--;
                    if (!is_cur(b)) begin
                        if (m_cur_v && m_state[m_cur_i] == SL_QUEUED)
                            m_state[m_cur_i] = SL_FREE;
                        m_cur_v = 1'b1;
                        m_cur_i = 5'(b);
                        m_cur_xf = m_sxf[b];
                        m_cur_t = m_stime[b];
                        r.newcur = 1'b1;
                    end
                end
                r.slot = m_cur_i;
                r.xform = m_cur_xf;
                r.stamp = m_cur_t;
            end
            default: r.status = STS_INVALID;
        endcase
    endtask

    task automatic send_item(input logic [2:0] c, input logic [4:0] s,
                             input logic [63:0] ts, input logic typed,
                             input logic [1:0] st);
        t_result r;
        int pct;
        pct = (idle_mode == 1) ? 63 : (idle_mode == 2) ? 8 : 0;
        while ($urandom_range(0, 99) < pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_cmd <= c;
        i_slot <= s;
        i_timestamp <= ts;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        predict_slot_op(c, s, ts, r);
        if (typed) r.status = st;
        pending_results = {pending_results, r};
        n_items++;
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_SYNC:   m_sync = val[0];
            CFG_CLIENT: m_client = val[0];
            CFG_COUNT:  m_count = val[5:0];
            default:    m_xform = val;
        endcase
    endtask

    task automatic random_item();
        logic [2:0]  c;
        logic [4:0]  s;
        logic [63:0] ts;
        int r, cnt, nd;
        int deq_list [$];
        cnt = slots_in_use();
        r = $urandom_range(0, 99);
        if (r < 22) c = CMD_DEQUEUE;
        else if (r < 34) c = CMD_REQUEST;
        else if (r < 60) c = CMD_QUEUE;
        else if (r < 70) c = CMD_CANCEL;
        else if (r < 95) c = CMD_ACQUIRE;
        else c = 3'($urandom_range(5, 7));
        for (int i = 0; i < SLOT_COUNT; i++)
            if (m_state[i] == SL_DEQ) deq_list = {deq_list, i};
        nd = deq_list.size();
        if ((c == CMD_QUEUE || c == CMD_CANCEL) && nd != 0 && $urandom_range(0, 99) < 65)
            s = 5'(deq_list[$urandom_range(0, nd - 1)]);
        else if ($urandom_range(0, 99) < 70)
            s = 5'($urandom_range(0, cnt - 1));
        else
            s = 5'($urandom_range(0, 31));
        r = $urandom_range(0, 99);
        if (r < 3) ts = 64'h7fff_ffff_ffff_ffff;
        else if (r < 6) ts = 64'h8000_0000_0000_0000;
        else ts = {$urandom, $urandom};
        send_item(c, s, ts, 1'b0, STS_OK);
    endtask

    // result check
    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (i_rst_n && o_valid) begin
            got = '{o_status, o_out_slot, o_frame_available, o_new_current,
                    o_out_transform, o_out_timestamp};
            n_results++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                fails++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r) begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
                    fails++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("FAIL frame_buffer_slot_queue");
            $finish;
        end
    end

    initial begin
        dir_tab = '{
            '{CMD_ACQUIRE, 5'd0,  64'd0,                 1'b1, STS_OK},
            '{CMD_DEQUEUE, 5'd0,  64'd0,                 1'b0, STS_OK},
            '{CMD_DEQUEUE, 5'd0,  64'd0,                 1'b1, STS_INVALID},
            '{CMD_QUEUE,   5'd0,  64'd5,                 1'b1, STS_INVALID},
            '{CMD_REQUEST, 5'd31, 64'd0,                 1'b1, STS_INVALID},
            '{CMD_REQUEST, 5'd0,  64'd0,                 1'b1, STS_OK},
            '{CMD_QUEUE,   5'd0,  64'h7fff_ffff_ffff_ffff, 1'b1, STS_OK},
            '{CMD_DEQUEUE, 5'd0,  64'd0,                 1'b0, STS_OK},
            '{CMD_REQUEST, 5'd1,  64'd0,                 1'b1, STS_OK},
            '{CMD_QUEUE,   5'd1,  64'h8000_0000_0000_0000, 1'b1, STS_OK},
            '{CMD_ACQUIRE, 5'd0,  64'd0,                 1'b0, STS_OK},
            '{CMD_ACQUIRE, 5'd0,  64'd0,                 1'b0, STS_OK},
            '{CMD_CANCEL,  5'd5,  64'd0,                 1'b1, STS_INVALID},
            '{CMD_CANCEL,  5'd0,  64'd0,                 1'b1, STS_INVALID},
            '{CMD_DEQUEUE, 5'd0,  64'd0,                 1'b0, STS_OK},
            '{CMD_CANCEL,  5'd0,  64'd0,                 1'b1, STS_OK},
            '{3'd5,        5'd31, 64'hffff_ffff_ffff_ffff, 1'b1, STS_INVALID},
            '{3'd6,        5'd0,  64'd0,                 1'b1, STS_INVALID},
            '{3'd7,        5'd31, 64'd0,                 1'b1, STS_INVALID},
            '{CMD_DEQUEUE, 5'd0,  64'd0,                 1'b0, STS_OK},
            '{CMD_REQUEST, 5'd2,  64'd0,                 1'b0, STS_OK},
            '{CMD_QUEUE,   5'd2,  64'h1234_5678_9abc_def0, 1'b0, STS_OK}
        };
        m_sync = 0; m_client = 0; m_count = 3; m_xform = 0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            m_state[i] = SL_FREE; m_req[i] = 0; m_sxf[i] = 0; m_stime[i] = 0; m_fifo[i] = 0;
        end
        m_head = 0; m_fcnt = 0; m_cur_v = 0; m_cur_i = 0; m_cur_xf = 0; m_cur_t = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIR; k++)
            send_item(dir_tab[k].cmd, dir_tab[k].slot, dir_tab[k].stamp,
                      dir_tab[k].typed, dir_tab[k].status);
        drain_results();

        for (int p = 1; p < N_PHASE; p++) begin
            write_reg(CFG_SYNC, ph_sync[p]);
            write_reg(CFG_CLIENT, ph_cli[p]);
            write_reg(CFG_COUNT, ph_cnt[p]);
            write_reg(CFG_XFORM, ph_xf[p]);
            i_cfg_we <= 1'b0;
            idle_mode = p % 3;
            for (int k = 0; k < ITEMS_PER_PH; k++) begin
                if (p == 2 && k == ITEMS_PER_PH / 2) drain_results();
                random_item();
            end
            drain_results();
        end

        repeat (6) @(posedge i_clk);
        $display("run covered %0d items and %0d results over %0d register settings",
                 n_items, n_results, N_PHASE);
        $display("sync and async queueing, single and multi slot producers, counts 2 to 32");
        if (fails == 0) begin
            $display("PASS frame_buffer_slot_queue");
        end else begin
            $display("FAIL frame_buffer_slot_queue");
        end
        $finish;
    end

endmodule
